// ===== src/bab_pkg.sv =====
// Shared types, constants and codes for the block allocation bitmap.
package bab_pkg;

   // map geometry
   localparam int WORD_BITS  = 32;
   localparam int MAP_WORDS  = 64;
   localparam int TOTAL_BITS = WORD_BITS * MAP_WORDS;
   localparam int BIT_IDX_W  = $clog2(WORD_BITS);
   localparam int WORD_IDX_W = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
   localparam int BLK_W      = BIT_IDX_W + WORD_IDX_W;

   // field widths
   localparam int ACTION_W   = 2;
   localparam int BLKNUM_W   = 16;
   localparam int ALLOC_W    = 11;
   localparam int COUNT_W    = 12;
   localparam int USABLE_W   = 12;
   localparam int DIR_W      = 5;
   localparam int COUNT_MAX  = 4095;

   // configuration port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [USABLE_W-1:0] USABLE_RESET = USABLE_W'(2048);
   localparam logic [DIR_W-1:0]    DIR_RESET    = DIR_W'(2);

   typedef enum logic [0:0] {
      REG_USABLE = 1'b0,
      REG_DIR    = 1'b1
   } reg_index_type;

   typedef enum logic [ACTION_W-1:0] {
      ACT_CLEAR = 2'd0,
      ACT_MARK  = 2'd1,
      ACT_ALLOC = 2'd2,
      ACT_NOP   = 2'd3
   } action_type;

   typedef struct packed {
      logic [ACTION_W-1:0] action;
      logic [BLKNUM_W-1:0] block_number;
   } req_payload_type;

   typedef struct packed {
      logic [ALLOC_W-1:0] allocated_block;
      logic               disk_full;
      logic               bad_block;
      logic [COUNT_W-1:0] used_count;
   } rsp_payload_type;

   typedef struct packed {
      logic [USABLE_W-1:0] usable_blocks;
      logic [DIR_W-1:0]    dir_blocks;
   } cfg_type;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_CLEAR,
      ST_MARK_RD,
      ST_MARK_WR,
      ST_SCAN,
      ST_DONE
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic start;     // latch request beat, reset address and result
      logic init_wr;   // write zero at sweep address, advance
      logic clr_wr;    // write directory pattern at sweep address, advance
      logic mark_rd;   // read the word holding the marked block
      logic mark_wr;   // set the marked bit
      logic scan_rd;   // read the word at scan address, advance
      logic alloc_wr;  // decide the allocation from the word just read
      logic load_rsp;  // copy result into output register
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic addr_last;  // sweep address is on the last word
      logic scan_hit;   // word just read has a clear bit
      logic scan_end;   // word just read is the last word
   } status_type;

endpackage

// ===== src/block_allocation_bitmap_top.sv =====
// Top level of the block allocation bitmap.
//
// Keeps one bit per disk block (64 words of 32 bits) and a count of used
// blocks. Request beats on req_* carry an action and a block number:
// clear (zero the map, reserve dir_blocks low blocks), mark (set one block,
// flag numbers beyond the map), allocate (take the lowest clear block below
// usable_blocks, or report full). Each request gives one response beat on
// rsp_* with the allocated block, full and bad flags and the used count.
// A clear writes every map word in turn, a mark reads and then writes one
// word, a no-op goes straight to the response, and an allocate scans the
// map one word per cycle until a word with a clear bit or the last word.
// One request is in work at a time; req_ready is high while idle, which is
// the cycle after the response loads. A request may be taken while the
// previous response still waits. If rsp_ready stays low, the next result
// is held back until the output register frees. After reset a sweep over
// all map words zeroes the map, with req_ready low; csr_* writes are taken
// at any time and should only be issued while idle. Registers:
// usable_blocks at 0x0, dir_blocks at 0x4.
module block_allocation_bitmap_top
   import bab_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_payload_type       req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_payload_type       rsp_data,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   cfg_type    cfg;
   cmd_type    cmd;
   status_type status;

   bab_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   bab_dp u_dp (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .cfg      (cfg),
      .req_data (req_data),
      .status   (status),
      .rsp_data (rsp_data)
   );

   bab_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_action (req_data.action),
      .req_ready  (req_ready),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .status     (status),
      .cmd        (cmd)
   );

endmodule

// ===== src/bab_csr.sv =====
// Configuration registers behind the APB-style port.
module bab_csr
   import bab_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output cfg_type               cfg
);

   logic [USABLE_W-1:0] usable_ff, usable_in;
   logic [DIR_W-1:0]    dir_ff, dir_in;
   reg_index_type       index;
   logic                wr_en;

   assign index      = reg_index_type'(csr_paddr[2]);
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;

   // register write decode
   always_comb begin
      usable_in = usable_ff;
      dir_in    = dir_ff;
      if (wr_en) begin
         unique case (index)
            REG_USABLE: usable_in = csr_pwdata[USABLE_W-1:0];
            REG_DIR:    dir_in    = csr_pwdata[DIR_W-1:0];
            default:    ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         usable_ff <= USABLE_RESET;
         dir_ff    <= DIR_RESET;
      end else begin
         usable_ff <= usable_in;
         dir_ff    <= dir_in;
      end
   end

   // read mux
   always_comb begin
      unique case (index)
         REG_USABLE: csr_prdata = CSR_DATA_W'(usable_ff);
         REG_DIR:    csr_prdata = CSR_DATA_W'(dir_ff);
         default:    csr_prdata = '0;
      endcase
   end

   assign cfg.usable_blocks = usable_ff;
   assign cfg.dir_blocks    = dir_ff;

endmodule

// ===== src/bab_dp.sv =====
// Datapath: map memory, sweep/scan address, used count and result registers.
module bab_dp
   import bab_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  cmd_type         cmd,
   input  cfg_type         cfg,
   input  req_payload_type req_data,
   output status_type      status,
   output rsp_payload_type rsp_data
);

   logic [WORD_BITS-1:0]  map_mem [MAP_WORDS];
   logic [WORD_BITS-1:0]  rd_data_ff;
   logic [WORD_IDX_W-1:0] rd_word_ff;
   logic                  rd_vld_ff, rd_vld_in;

   req_payload_type       req_ff, req_in;
   logic [WORD_IDX_W-1:0] addr_ff, addr_in;
   logic [COUNT_W-1:0]    used_ff, used_in;
   logic [ALLOC_W-1:0]    alloc_ff, alloc_in;
   logic                  full_ff, full_in;
   logic                  bad_ff, bad_in;
   rsp_payload_type       rsp_ff, rsp_in;

   logic [WORD_IDX_W-1:0] rd_addr;
   logic                  wr_en;
   logic [WORD_IDX_W-1:0] wr_addr;
   logic [WORD_BITS-1:0]  wr_data;

   logic                  mark_bad;
   logic [WORD_IDX_W-1:0] mark_word;
   logic [BIT_IDX_W-1:0]  mark_bit;
   logic [WORD_BITS-1:0]  mark_mask;
   logic [WORD_BITS-1:0]  dir_mask;
   logic [COUNT_W-1:0]    dir_count;
   logic [COUNT_W-1:0]    used_inc;
   logic                  free_found;
   logic [BIT_IDX_W-1:0]  free_bit;
   logic [WORD_BITS-1:0]  free_mask;
   logic [BLK_W-1:0]      cand;
   logic                  cand_ok;

   // mark decode
   assign mark_bad  = 32'(req_ff.block_number) >= 32'(TOTAL_BITS);
   assign mark_word = req_ff.block_number[BIT_IDX_W +: WORD_IDX_W];
   assign mark_bit  = req_ff.block_number[BIT_IDX_W-1:0];
   assign mark_mask = WORD_BITS'(1) << mark_bit;

   // directory pattern for the word at the sweep address
   always_comb begin
      for (int i = 0; i < WORD_BITS; i++) begin
         dir_mask[i] = (32'(addr_ff) * 32'(WORD_BITS) + 32'(i)) < 32'(cfg.dir_blocks);
      end
      if (32'(cfg.dir_blocks) > 32'(TOTAL_BITS)) dir_count = COUNT_W'(TOTAL_BITS);
      else                                       dir_count = COUNT_W'(cfg.dir_blocks);
   end

   // lowest clear bit of the word just read
   always_comb begin
      free_found = 1'b0;
      free_bit   = '0;
      for (int i = 0; i < WORD_BITS; i++) begin
         if (!free_found && !rd_data_ff[i]) begin
            free_found = 1'b1;
            free_bit   = BIT_IDX_W'(i);
         end
      end
      free_mask = WORD_BITS'(1) << free_bit;
   end

   assign cand    = {rd_word_ff, free_bit};
   assign cand_ok = free_found && (32'(cand) < 32'(cfg.usable_blocks));

   assign used_inc = (32'(used_ff) < COUNT_MAX) ? used_ff + COUNT_W'(1) : used_ff;

   assign rd_addr = cmd.mark_rd ? mark_word : addr_ff;

   // write port select and datapath register updates
   always_comb begin
      wr_en     = 1'b0;
      wr_addr   = addr_ff;
      wr_data   = '0;
      req_in    = req_ff;
      addr_in   = addr_ff;
      used_in   = used_ff;
      alloc_in  = alloc_ff;
      full_in   = full_ff;
      bad_in    = bad_ff;
      rsp_in    = rsp_ff;
      rd_vld_in = cmd.scan_rd;

      if (cmd.start) begin
         req_in   = req_data;
         addr_in  = '0;
         alloc_in = '0;
         full_in  = 1'b0;
         bad_in   = 1'b0;
      end
      if (cmd.init_wr) begin
         wr_en   = 1'b1;
         addr_in = addr_ff + WORD_IDX_W'(1);
      end
      if (cmd.clr_wr) begin
         wr_en   = 1'b1;
         wr_data = dir_mask;
         addr_in = addr_ff + WORD_IDX_W'(1);
         if (addr_ff == '0) used_in = dir_count;
      end
      if (cmd.mark_wr) begin
         bad_in = mark_bad;
         if (!mark_bad && !rd_data_ff[mark_bit]) begin
            wr_en   = 1'b1;
            wr_addr = mark_word;
            wr_data = rd_data_ff | mark_mask;
            used_in = used_inc;
         end
      end
      if (cmd.scan_rd) begin
         addr_in = addr_ff + WORD_IDX_W'(1);
      end
      if (cmd.alloc_wr) begin
         if (cand_ok) begin
            wr_en    = 1'b1;
            wr_addr  = rd_word_ff;
            wr_data  = rd_data_ff | free_mask;
            used_in  = used_inc;
            alloc_in = ALLOC_W'(cand);
         end else begin
            full_in  = 1'b1;
         end
      end
      if (cmd.load_rsp) begin
         rsp_in.allocated_block = alloc_ff;
         rsp_in.disk_full       = full_ff;
         rsp_in.bad_block       = bad_ff;
         rsp_in.used_count      = used_ff;
      end
   end

   // map memory: one write, one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) map_mem[wr_addr] <= wr_data;
      rd_data_ff <= map_mem[rd_addr];
      rd_word_ff <= rd_addr;
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         addr_ff   <= '0;
         used_ff   <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         addr_ff   <= addr_in;
         used_ff   <= used_in;
         rd_vld_ff <= rd_vld_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      req_ff   <= req_in;
      alloc_ff <= alloc_in;
      full_ff  <= full_in;
      bad_ff   <= bad_in;
      rsp_ff   <= rsp_in;
   end

   assign status.addr_last = (32'(addr_ff) == MAP_WORDS - 1);
   assign status.scan_hit  = rd_vld_ff && (rd_data_ff != '1);
   assign status.scan_end  = rd_vld_ff && (32'(rd_word_ff) == MAP_WORDS - 1);

   assign rsp_data = rsp_ff;

endmodule

// ===== src/bab_ctrl.sv =====
// Controller: sequences init sweep, clear, mark and allocate scan.
module bab_ctrl
   import bab_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic [ACTION_W-1:0] req_action,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;

      unique case (state_ff)
         ST_INIT: begin
            cmd.init_wr = 1'b1;
            if (status.addr_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.start = 1'b1;
               unique case (action_type'(req_action))
                  ACT_CLEAR: state_in = ST_CLEAR;
                  ACT_MARK:  state_in = ST_MARK_RD;
                  ACT_ALLOC: state_in = ST_SCAN;
                  default:   state_in = ST_DONE;
               endcase
            end
         end
         ST_CLEAR: begin
            cmd.clr_wr = 1'b1;
            if (status.addr_last) state_in = ST_DONE;
         end
         ST_MARK_RD: begin
            cmd.mark_rd = 1'b1;
            state_in    = ST_MARK_WR;
         end
         ST_MARK_WR: begin
            cmd.mark_wr = 1'b1;
            state_in    = ST_DONE;
         end
         ST_SCAN: begin
            if (status.scan_hit || status.scan_end) begin
               cmd.alloc_wr = 1'b1;
               state_in     = ST_DONE;
            end else begin
               cmd.scan_rd  = 1'b1;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // output beat valid
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_ready) rsp_valid_in = 1'b0;
      if (cmd.load_rsp) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule
